// ===== hw/rtl/fzc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fzc_pkg;

    localparam int DATA_W = 16;
    typedef logic signed [DATA_W-1:0] q88_t;

    // output universe
    localparam int OUT_LOW           = -25;
    localparam int OUT_HIGH          = 100;
    localparam int OPEN_FULL_POINT   = 50;
    localparam int CLOSED_HALF_WIDTH = 25;

    // grades: unsigned fraction, GRADE_ONE is one
    localparam int GRADE_ONE   = 65536;
    localparam int GRADE_W     = 17;
    localparam int GRADE_DEN_W = 16;
    localparam int GRADE_STEPS = GRADE_W;
    typedef logic [GRADE_W-1:0] grade_t;

    localparam int PTS_PER_CELL = 2;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_NEG_FULL  = 3'd0;
    localparam cfg_idx_t REG_NEG_ZERO  = 3'd1;
    localparam cfg_idx_t REG_ZERO_LEFT = 3'd2;
    localparam cfg_idx_t REG_ZERO_PEAK = 3'd3;
    localparam cfg_idx_t REG_ZERO_RIGHT = 3'd4;
    localparam cfg_idx_t REG_POS_ZERO  = 3'd5;
    localparam cfg_idx_t REG_POS_FULL  = 3'd6;

    localparam q88_t RST_NEG_FULL   = -16'sd2560;
    localparam q88_t RST_NEG_ZERO   = 16'sd0;
    localparam q88_t RST_ZERO_LEFT  = -16'sd1280;
    localparam q88_t RST_ZERO_PEAK  = 16'sd0;
    localparam q88_t RST_ZERO_RIGHT = 16'sd1280;
    localparam q88_t RST_POS_ZERO   = 16'sd0;
    localparam q88_t RST_POS_FULL   = 16'sd2560;

    localparam int APERTURE_MAX = 32767;
    localparam int APERTURE_MIN = -32768;

endpackage

`default_nettype wire

// ===== hw/rtl/fzc_err_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fzc_err_if;
    logic              valid;
    logic              ready;
    fzc_pkg::q88_t     error_value;

    modport source (output valid, output error_value, input ready);
    modport sink   (input valid, input error_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fzc_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fzc_res_if;
    logic              valid;
    logic              ready;
    fzc_pkg::q88_t     aperture;
    logic              no_rule_fired;

    modport source (output valid, output aperture, output no_rule_fired, input ready);
    modport sink   (input valid, input aperture, input no_rule_fired, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fzc_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fzc_cfg_if;
    logic                  valid;
    logic                  ready;
    fzc_pkg::cfg_idx_t     index;
    fzc_pkg::q88_t         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fzc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One restoring-division step. w carries the remaining dividend bits at the
// top and collects quotient bits at the bottom.
module fzc_div_cell #(
    parameter int DW = 16,
    parameter int LW = 17
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] r_in,
    input  wire logic [DW-1:0] d_in,
    input  wire logic [LW-1:0] w_in,
    output logic      [DW-1:0] r_out,
    output logic      [DW-1:0] d_out,
    output logic      [LW-1:0] w_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] r_next;
    logic [DW-1:0] d_reg;
    logic [LW-1:0] w_reg;
    logic [LW-1:0] w_next;

    assign trial  = {r_in, w_in[LW-1]};
    assign diff   = trial - {1'b0, d_in};
    assign take   = (trial >= {1'b0, d_in});
    assign r_next = take ? diff[DW-1:0] : trial[DW-1:0];
    assign w_next = {w_in[LW-2:0], take};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            d_reg <= d_in;
            w_reg <= w_next;
        end
    end

    assign r_out = r_reg;
    assign d_out = d_reg;
    assign w_out = w_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fzc_agg_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adds the clipped weights of a few consecutive output points into the
// running moment and weight sums.
module fzc_agg_cell #(
    parameter int FIRST_POINT = 0,
    parameter int OUT_HIGH    = fzc_pkg::OUT_HIGH,
    parameter int CHW         = fzc_pkg::CLOSED_HALF_WIDTH,
    parameter int OFP         = fzc_pkg::OPEN_FULL_POINT,
    parameter int TOP_W       = 32,
    parameter int BOT_W       = 24
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire fzc_pkg::grade_t         lo_in,
    input  wire fzc_pkg::grade_t         hi_in,
    input  wire logic signed [TOP_W-1:0] top_in,
    input  wire logic        [BOT_W-1:0] bot_in,
    output fzc_pkg::grade_t              lo_out,
    output fzc_pkg::grade_t              hi_out,
    output logic signed      [TOP_W-1:0] top_out,
    output logic             [BOT_W-1:0] bot_out
);

    localparam int PPC = fzc_pkg::PTS_PER_CELL;

    logic signed [TOP_W-1:0] prod [PPC];
    logic        [BOT_W-1:0] wext [PPC];
    logic signed [TOP_W-1:0] top_next;
    logic        [BOT_W-1:0] bot_next;
    fzc_pkg::grade_t         lo_reg;
    fzc_pkg::grade_t         hi_reg;
    logic signed [TOP_W-1:0] top_reg;
    logic        [BOT_W-1:0] bot_reg;

    for (genvar j = 0; j < PPC; j++)
    begin : g_pt
        localparam int P      = FIRST_POINT + j;
        localparam int AP     = (P < 0) ? -P : P;
        localparam int CLS    = (AP <= CHW) ? ((CHW - AP) * fzc_pkg::GRADE_ONE) / CHW : 0;
        localparam int OPN    = (P >= OFP) ? fzc_pkg::GRADE_ONE :
                                ((P > 0) ? (P * fzc_pkg::GRADE_ONE) / OFP : 0);
        localparam int MU     = (CLS > OPN) ? CLS : OPN;
        localparam bit USE_LO = (P <= CHW);
        localparam bit LIVE   = (P <= OUT_HIGH);
        localparam fzc_pkg::grade_t        MU_G = fzc_pkg::GRADE_W'(MU);
        localparam logic signed [TOP_W-1:0] PS  = TOP_W'(P);

        fzc_pkg::grade_t         clip;
        fzc_pkg::grade_t         w;
        logic signed [TOP_W-1:0] wx;

        assign clip = USE_LO ? lo_in : hi_in;
        assign w    = LIVE ? ((clip < MU_G) ? clip : MU_G) : '0;
        assign wx   = signed'(TOP_W'(w));
        assign prod[j] = wx * PS;
        assign wext[j] = BOT_W'(w);
    end

    always_comb
    begin
        top_next = top_in;
        bot_next = bot_in;
        for (int j = 0; j < PPC; j++)
        begin
            top_next = top_next + prod[j];
            bot_next = bot_next + wext[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg  <= lo_in;
            hi_reg  <= hi_in;
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;
    assign top_out = top_reg;
    assign bot_out = bot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fuzzy_level_controller_inference_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: a grade setup register, a row of division cells for the grades,
// a row of summing cells over the output points (-25..100 by default), a
// centroid setup register, a row of division cells for the centroid and an
// output register; every stage holds a word of its own.
// Throughput: one word per cycle while res_out.ready is held high.
// Reset: pipeline emptied, configuration registers at their default shapes.
module fuzzy_level_controller_inference_top #(
    parameter int OUT_LOW           = fzc_pkg::OUT_LOW,
    parameter int OUT_HIGH          = fzc_pkg::OUT_HIGH,
    parameter int OPEN_FULL_POINT   = fzc_pkg::OPEN_FULL_POINT,
    parameter int CLOSED_HALF_WIDTH = fzc_pkg::CLOSED_HALF_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fzc_err_if.sink    err_in,
    fzc_res_if.source  res_out,
    fzc_cfg_if.sink    cfg
);

    localparam int     NPTS    = OUT_HIGH - OUT_LOW + 1;
    localparam int     MAXP    = (OUT_HIGH > -OUT_LOW) ? OUT_HIGH : -OUT_LOW;
    localparam longint BOT_MAX = longint'(NPTS) * fzc_pkg::GRADE_ONE;
    localparam int     BOT_W   = $clog2(BOT_MAX + 1);
    localparam int     TOP_W   = $clog2(BOT_MAX * MAXP + 1) + 1;
    localparam int     QW      = $clog2(MAXP * 256 + 1);
    localparam int     DVW     = TOP_W + 10;
    localparam int     FDW     = BOT_W + 1;
    localparam int     PPC     = fzc_pkg::PTS_PER_CELL;
    localparam int     NC      = (NPTS + PPC - 1) / PPC;
    localparam int     GB      = fzc_pkg::GRADE_STEPS;
    localparam int     GDW     = fzc_pkg::GRADE_DEN_W;
    localparam int     AGG0    = 1 + GB;
    localparam int     FS      = AGG0 + NC;
    localparam int     OS      = FS + QW + 1;
    localparam int     NS      = OS + 1;

    // ---------------- configuration ----------------
    fzc_pkg::q88_t neg_full_reg, neg_zero_reg, zero_left_reg, zero_peak_reg;
    fzc_pkg::q88_t zero_right_reg, pos_zero_reg, pos_full_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_full_reg   <= fzc_pkg::RST_NEG_FULL;
            neg_zero_reg   <= fzc_pkg::RST_NEG_ZERO;
            zero_left_reg  <= fzc_pkg::RST_ZERO_LEFT;
            zero_peak_reg  <= fzc_pkg::RST_ZERO_PEAK;
            zero_right_reg <= fzc_pkg::RST_ZERO_RIGHT;
            pos_zero_reg   <= fzc_pkg::RST_POS_ZERO;
            pos_full_reg   <= fzc_pkg::RST_POS_FULL;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fzc_pkg::REG_NEG_FULL:   neg_full_reg   <= cfg.data;
                fzc_pkg::REG_NEG_ZERO:   neg_zero_reg   <= cfg.data;
                fzc_pkg::REG_ZERO_LEFT:  zero_left_reg  <= cfg.data;
                fzc_pkg::REG_ZERO_PEAK:  zero_peak_reg  <= cfg.data;
                fzc_pkg::REG_ZERO_RIGHT: zero_right_reg <= cfg.data;
                fzc_pkg::REG_POS_ZERO:   pos_zero_reg   <= cfg.data;
                fzc_pkg::REG_POS_FULL:   pos_full_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;

    assign adv[NS] = res_out.ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= err_in.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign err_in.ready = adv[0];

    // ---------------- grade setup ----------------
    // Each grade becomes num/den; one is 1/1 and zero is 0/1.
    logic signed [16:0] e, nf, nz, zl, zp, zr, pz, pf;
    logic signed [16:0] n_num, n_den, z_num, z_den, p_num, p_den;

    assign e  = 17'(err_in.error_value);
    assign nf = 17'(neg_full_reg);
    assign nz = 17'(neg_zero_reg);
    assign zl = 17'(zero_left_reg);
    assign zp = 17'(zero_peak_reg);
    assign zr = 17'(zero_right_reg);
    assign pz = 17'(pos_zero_reg);
    assign pf = 17'(pos_full_reg);

    always_comb
    begin
        if (e <= nf)
        begin
            n_num = 17'sd1;
            n_den = 17'sd1;
        end
        else if (e < nz)
        begin
            n_num = nz - e;
            n_den = nz - nf;
        end
        else
        begin
            n_num = 17'sd0;
            n_den = 17'sd1;
        end

        if (e >= pf)
        begin
            p_num = 17'sd1;
            p_den = 17'sd1;
        end
        else if (e > pz)
        begin
            p_num = e - pz;
            p_den = pf - pz;
        end
        else
        begin
            p_num = 17'sd0;
            p_den = 17'sd1;
        end

        if (e < zl || e > zr)
        begin
            z_num = 17'sd0;
            z_den = 17'sd1;
        end
        else if (e <= zp)
        begin
            if (zp == zl)
            begin
                z_num = 17'sd1;
                z_den = 17'sd1;
            end
            else
            begin
                z_num = e - zl;
                z_den = zp - zl;
            end
        end
        else
        begin
            z_num = zr - e;
            z_den = zr - zp;
        end
    end

    // lanes: 0 negative, 1 zero, 2 positive
    logic [GDW-1:0]     gr [GB+1][3];
    logic [GDW-1:0]     gd [GB+1][3];
    logic [GB-1:0]      gw [GB+1][3];
    logic [GDW-1:0]     gr0_reg [3];
    logic [GDW-1:0]     gd0_reg [3];
    logic [GB-1:0]      gw0_reg [3];
    logic [GDW-1:0]     num_lane [3];
    logic [GDW-1:0]     den_lane [3];

    assign num_lane[0] = n_num[GDW-1:0];
    assign num_lane[1] = z_num[GDW-1:0];
    assign num_lane[2] = p_num[GDW-1:0];
    assign den_lane[0] = n_den[GDW-1:0];
    assign den_lane[1] = z_den[GDW-1:0];
    assign den_lane[2] = p_den[GDW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int l = 0; l < 3; l++)
            begin
                gr0_reg[l] <= {1'b0, num_lane[l][GDW-1:1]};
                gd0_reg[l] <= den_lane[l];
                gw0_reg[l] <= {num_lane[l][0], {(GB-1){1'b0}}};
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign gr[0][l] = gr0_reg[l];
        assign gd[0][l] = gd0_reg[l];
        assign gw[0][l] = gw0_reg[l];
        for (genvar i = 0; i < GB; i++)
        begin : g_step
            fzc_div_cell #(
                .DW (GDW),
                .LW (GB)
            ) u_gdiv (
                .clk   (clk),
                .en    (adv[1+i]),
                .r_in  (gr[i][l]),
                .d_in  (gd[i][l]),
                .w_in  (gw[i][l]),
                .r_out (gr[i+1][l]),
                .d_out (gd[i+1][l]),
                .w_out (gw[i+1][l])
            );
        end
    end

    // ---------------- aggregation ----------------
    fzc_pkg::grade_t         alo [NC+1];
    fzc_pkg::grade_t         ahi [NC+1];
    logic signed [TOP_W-1:0] atop [NC+1];
    logic        [BOT_W-1:0] abot [NC+1];

    assign alo[0]  = (gw[GB][0] < gw[GB][1]) ? gw[GB][0] : gw[GB][1];
    assign ahi[0]  = gw[GB][2];
    assign atop[0] = '0;
    assign abot[0] = '0;

    for (genvar c = 0; c < NC; c++)
    begin : g_agg
        fzc_agg_cell #(
            .FIRST_POINT (OUT_LOW + c * PPC),
            .OUT_HIGH    (OUT_HIGH),
            .CHW         (CLOSED_HALF_WIDTH),
            .OFP         (OPEN_FULL_POINT),
            .TOP_W       (TOP_W),
            .BOT_W       (BOT_W)
        ) u_agg (
            .clk     (clk),
            .en      (adv[AGG0+c]),
            .lo_in   (alo[c]),
            .hi_in   (ahi[c]),
            .top_in  (atop[c]),
            .bot_in  (abot[c]),
            .lo_out  (alo[c+1]),
            .hi_out  (ahi[c+1]),
            .top_out (atop[c+1]),
            .bot_out (abot[c+1])
        );
    end

    // ---------------- centroid division setup ----------------
    // q = (2*|top|*256 + bot) / (2*bot): rounds half away from zero
    logic                neg_now;
    logic [TOP_W-1:0]    mag;
    logic [DVW-1:0]      dvd;
    logic [FDW-1:0]      fr [QW+1];
    logic [FDW-1:0]      fd [QW+1];
    logic [QW-1:0]       fw [QW+1];
    logic [FDW-1:0]      fr0_reg;
    logic [FDW-1:0]      fd0_reg;
    logic [QW-1:0]       fw0_reg;
    logic [QW:0]         fneg_reg;
    logic [QW:0]         fzero_reg;

    assign neg_now = atop[NC][TOP_W-1];
    assign mag     = neg_now ? TOP_W'(-atop[NC]) : TOP_W'(atop[NC]);
    assign dvd     = (DVW'(mag) << 9) + DVW'(abot[NC]);

    always_ff @(posedge clk)
    begin
        if (adv[FS])
        begin
            fr0_reg      <= FDW'(dvd >> QW);
            fd0_reg      <= {abot[NC], 1'b0};
            fw0_reg      <= dvd[QW-1:0];
            fneg_reg[0]  <= neg_now;
            fzero_reg[0] <= (abot[NC] == '0);
        end
        for (int k = 1; k <= QW; k++)
        begin
            if (adv[FS+k])
            begin
                fneg_reg[k]  <= fneg_reg[k-1];
                fzero_reg[k] <= fzero_reg[k-1];
            end
        end
    end

    assign fr[0] = fr0_reg;
    assign fd[0] = fd0_reg;
    assign fw[0] = fw0_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_fdiv
        fzc_div_cell #(
            .DW (FDW),
            .LW (QW)
        ) u_fdiv (
            .clk   (clk),
            .en    (adv[FS+1+i]),
            .r_in  (fr[i]),
            .d_in  (fd[i]),
            .w_in  (fw[i]),
            .r_out (fr[i+1]),
            .d_out (fd[i+1]),
            .w_out (fw[i+1])
        );
    end

    // ---------------- output word ----------------
    logic signed [QW+1:0] sval;
    fzc_pkg::q88_t        ap_next;
    fzc_pkg::q88_t        aperture_reg;
    logic                 no_rule_reg;

    assign sval = fneg_reg[QW] ? -signed'((QW+2)'(fw[QW])) : signed'((QW+2)'(fw[QW]));

    always_comb
    begin
        if (fzero_reg[QW])
        begin
            ap_next = '0;
        end
        else if (sval > fzc_pkg::APERTURE_MAX)
        begin
            ap_next = fzc_pkg::DATA_W'(fzc_pkg::APERTURE_MAX);
        end
        else if (sval < fzc_pkg::APERTURE_MIN)
        begin
            ap_next = fzc_pkg::DATA_W'(fzc_pkg::APERTURE_MIN);
        end
        else
        begin
            ap_next = fzc_pkg::DATA_W'(sval);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[OS])
        begin
            aperture_reg <= ap_next;
            no_rule_reg  <= fzero_reg[QW];
        end
    end

    assign res_out.valid         = vld_reg[OS];
    assign res_out.aperture      = aperture_reg;
    assign res_out.no_rule_fired = no_rule_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 98;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fzc_err_if err_ch ();
    fzc_res_if res_ch ();
    fzc_cfg_if cfg_ch ();

    fuzzy_level_controller_inference_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .err_in  (err_ch.sink),
        .res_out (res_ch.source),
        .cfg     (cfg_ch.sink)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    typedef struct {
        logic signed [15:0] aperture;
        logic               no_rule_fired;
    } valve_word_t;

    // shapes as the predictor sees them
    logic signed [15:0] shape [0:6];

    logic signed [15:0] error_queue [$];
    valve_word_t        aperture_queue [$];

    int  fail_count = 0;
    bit  send_gaps = 1'b1;
    bit  recv_gaps = 1'b1;
    bit  send_hold = 1'b0;
    int  recv_hold_cycles = 0;
    bit  cfg_busy = 1'b0;
    bit  err_taken = 1'b0;

    function automatic longint frac(longint num, longint den);
        return (num * fzc_pkg::GRADE_ONE) / den;
    endfunction

    function automatic valve_word_t predict_aperture(logic signed [15:0] err);
        longint e, nf, nz, zl, zp, zr, pz, pf;
        longint gneg, gzero, gpos, low_clip, top, bot, ap, closed, open_g, w, num;
        longint mag, q;
        valve_word_t res;
        e = err;
        nf = shape[fzc_pkg::REG_NEG_FULL];
        nz = shape[fzc_pkg::REG_NEG_ZERO];
        zl = shape[fzc_pkg::REG_ZERO_LEFT];
        zp = shape[fzc_pkg::REG_ZERO_PEAK];
        zr = shape[fzc_pkg::REG_ZERO_RIGHT];
        pz = shape[fzc_pkg::REG_POS_ZERO];
        pf = shape[fzc_pkg::REG_POS_FULL];
        if (e <= nf) gneg = fzc_pkg::GRADE_ONE;
        else if (e < nz) gneg = frac(nz - e, nz - nf);
        else gneg = 0;
        if (e >= pf) gpos = fzc_pkg::GRADE_ONE;
        else if (e > pz) gpos = frac(e - pz, pf - pz);
        else gpos = 0;
        if (e < zl || e > zr) gzero = 0;
        else if (e <= zp) gzero = (zp == zl) ? fzc_pkg::GRADE_ONE : frac(e - zl, zp - zl);
        else gzero = frac(zr - e, zr - zp);
        low_clip = (gneg < gzero) ? gneg : gzero;
        top = 0;
        bot = 0;
        for (longint p = fzc_pkg::OUT_LOW; p <= fzc_pkg::OUT_HIGH; p++)
        begin
            ap = (p < 0) ? -p : p;
            closed = (ap <= fzc_pkg::CLOSED_HALF_WIDTH) ?
                     ((fzc_pkg::CLOSED_HALF_WIDTH - ap) * fzc_pkg::GRADE_ONE) /
                     fzc_pkg::CLOSED_HALF_WIDTH : 0;
            if (p >= fzc_pkg::OPEN_FULL_POINT) open_g = fzc_pkg::GRADE_ONE;
            else if (p > 0) open_g = (p * fzc_pkg::GRADE_ONE) / fzc_pkg::OPEN_FULL_POINT;
            else open_g = 0;
            w = (closed > open_g) ? closed : open_g;
            if (p <= fzc_pkg::CLOSED_HALF_WIDTH) w = (w < low_clip) ? w : low_clip;
            else w = (w < gpos) ? w : gpos;
            top += w * p;
            bot += w;
        end
        if (bot == 0)
        begin
            res.aperture = '0;
            res.no_rule_fired = 1'b1;
        end
        else
        begin
            num = top * 256;
            mag = (num < 0) ? -num : num;
            q = (2 * mag + bot) / (2 * bot);
            if (q > 32768) q = 32768;
            q = (num < 0) ? -q : q;
            if (q > fzc_pkg::APERTURE_MAX) q = fzc_pkg::APERTURE_MAX;
            res.aperture = q[15:0];
            res.no_rule_fired = 1'b0;
        end
        return res;
    endfunction

    // error sender
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            err_ch.valid <= 1'b0;
            err_ch.error_value <= '0;
        end
        else if (err_ch.valid && !err_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            err_ch.valid <= 1'b0;
        end
        else if (error_queue.size() > 0 && !send_hold && !cfg_busy)
        begin
            err_ch.valid <= 1'b1;
            err_ch.error_value <= error_queue[0];
            if (send_gaps && $urandom_range(0, 9) == 0)
                send_gap <= $urandom_range(1, 19);
        end
        else
            err_ch.valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        err_taken <= rst_n && err_ch.valid && err_ch.ready;
        if (rst_n && err_ch.valid && err_ch.ready)
        begin
            aperture_queue.insert(aperture_queue.size(),
                                  predict_aperture(err_ch.error_value));
            void'(error_queue.pop_front());
        end
    end

    // result receiver
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (recv_gaps && $urandom_range(0, 11) == 0)
                recv_gap <= $urandom_range(1, 19);
        end
    end

    always @(posedge clk)
    begin
        valve_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (aperture_queue.size() == 0)
            begin
                $display("%0t: unexpected word aperture=%0d no_rule=%0b", $time,
                         res_ch.aperture, res_ch.no_rule_fired);
                fail_count++;
            end
            else
            begin
                want = aperture_queue.pop_front();
                if (res_ch.aperture !== want.aperture)
                begin
                    $display("%0t: aperture expected %0d actual %0d", $time,
                             want.aperture, res_ch.aperture);
                    fail_count++;
                end
                if (res_ch.no_rule_fired !== want.no_rule_fired)
                begin
                    $display("%0t: no_rule_fired expected %0b actual %0b", $time,
                             want.no_rule_fired, res_ch.no_rule_fired);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_shape(fzc_pkg::cfg_idx_t idx, logic signed [15:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx <= fzc_pkg::REG_POS_FULL)
            shape[idx] = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (error_queue.size() > 0 || aperture_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // one register set per phase: defaults, extremes, flat shapes, reversed shapes, random
    task automatic load_shapes(int kind);
        logic signed [15:0] v [0:6];
        int base;
        case (kind)
            0: v = '{-16'sd2560, 16'sd0, -16'sd1280, 16'sd0, 16'sd1280, 16'sd0, 16'sd2560};
            1: v = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767,
                     -16'sd32768, 16'sd32767};
            2: v = '{16'sd100, 16'sd100, 16'sd50, 16'sd50, 16'sd50, 16'sd300, 16'sd300};
            3: v = '{16'sd500, -16'sd500, 16'sd400, -16'sd200, 16'sd100,
                     16'sd700, 16'sd600};
            default:
            begin
                base = $urandom_range(0, 4000) - 2000;
                v[0] = 16'(base - $urandom_range(1, 3000));
                v[1] = 16'(base + $urandom_range(0, 3000));
                v[2] = 16'(base - $urandom_range(1, 2000));
                v[3] = 16'(base + $urandom_range(0, 10) - 5);
                v[4] = 16'(v[3] + $urandom_range(0, 2000));
                v[5] = 16'(base - $urandom_range(0, 3000));
                v[6] = 16'(v[5] + $urandom_range(1, 3000));
            end
        endcase
        for (int i = 0; i < 7; i++)
            write_shape(fzc_pkg::cfg_idx_t'(i), v[i]);
        // index beyond the map is ignored
        write_shape(fzc_pkg::cfg_idx_t'(fzc_pkg::REG_POS_FULL + 1), 16'($urandom));
    endtask

    function automatic logic signed [15:0] rand_error();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8000) - 4000);
            2: return 16'(shape[$urandom_range(0, 6)] + $urandom_range(0, 4) - 2);
            default: return 16'($urandom_range(0, 800) - 400);
        endcase
    endfunction

    initial
    begin
        for (int i = 0; i < 7; i++)
            shape[i] = 16'sd0;
        shape[fzc_pkg::REG_NEG_FULL] = fzc_pkg::RST_NEG_FULL;
        shape[fzc_pkg::REG_ZERO_LEFT] = fzc_pkg::RST_ZERO_LEFT;
        shape[fzc_pkg::REG_ZERO_RIGHT] = fzc_pkg::RST_ZERO_RIGHT;
        shape[fzc_pkg::REG_POS_FULL] = fzc_pkg::RST_POS_FULL;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, on reset shapes
        error_queue = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd2560,
                        -16'sd1280, 16'sd1280, 16'sd2560, -16'sd640, 16'sd640, 16'sd1279,
                        -16'sd1279, 16'sd2559, 16'sd3000, -16'sd3000, 16'sh5555, -16'sh5556};
        drain();

        // receiver holds off while the sender keeps offering
        recv_hold_cycles = 400;
        for (int i = 0; i < 200; i++)
            error_queue.insert(error_queue.size(), rand_error());
        drain();

        for (int ph = 1; ph < 12; ph++)
        begin
            cfg_busy = 1'b1;
            load_shapes(ph);
            cfg_busy = 1'b0;
            // flat shapes and zero-width sides
            if (ph == 2)
                error_queue = '{16'sd50, 16'sd49, 16'sd51, 16'sd100, 16'sd300, 16'sd301};
            if (ph == 11)
            begin
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            for (int i = 0; i < 120; i++)
            begin
                error_queue.insert(error_queue.size(), rand_error());
                if (i == 60)
                begin
                    // sender pauses for all results
                    while (error_queue.size() > 0)
                        @(posedge clk);
                    send_hold = 1'b1;
                    while (aperture_queue.size() > 0)
                        @(posedge clk);
                    send_hold = 1'b0;
                end
            end
            drain();
        end
        cfg_busy = 1'b1;
        load_shapes(0);
        cfg_busy = 1'b0;
        for (int i = 0; i < 60; i++)
            error_queue.insert(error_queue.size(), rand_error());
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fzc_pkg.sv
hw/rtl/fzc_err_if.sv
hw/rtl/fzc_res_if.sv
hw/rtl/fzc_cfg_if.sv
hw/rtl/fzc_div_cell.sv
hw/rtl/fzc_agg_cell.sv
hw/rtl/fuzzy_level_controller_inference_top.sv
bench/tb_top.sv
